FILE: hdl/omd_pkg.sv
// Package: shared types, codes and constants of the opcode message deframer.
package omd_pkg;

  localparam int NUM_OPCODES_DEF   = 64;
  localparam int MAX_DGRAM_DEF     = 2048;
  localparam int FIFO_DEPTH        = 4;
  localparam int CFG_W             = 7;

  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  typedef enum logic [4:0] {
    PH_OP_LO  = 5'b00001,
    PH_OP_HI  = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_LEN_HI = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_opcode;
    logic [10:0] body_offset;
    logic [15:0] payload_length;
    logic        last_in_run;
  } res_t;

  // table entry as read back: fixed size plus dynamic-length flag
  typedef struct packed {
    logic        dynamic;
    logic [15:0] size;
  } entry_t;

endpackage

FILE: hdl/omd_if.sv
// Interfaces: input byte channel and result channel of the deframer.
interface omd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [5:0]  entry_index;
  logic [15:0] entry_size;
  logic        entry_dynamic;

  modport source (output valid, mode, data_byte, last_byte, entry_index, entry_size,
                  entry_dynamic, input ready);
  modport sink (input valid, mode, data_byte, last_byte, entry_index, entry_size,
                entry_dynamic, output ready);
endinterface

interface omd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] msg_opcode;
  logic [10:0] body_offset;
  logic [15:0] payload_length;
  logic        last_in_run;

  modport source (output valid, kind, msg_opcode, body_offset, payload_length,
                  last_in_run, input ready);
  modport sink (input valid, kind, msg_opcode, body_offset, payload_length,
                last_in_run, output ready);
endinterface

FILE: hdl/opcode_message_deframer.sv
// Top level of the opcode message deframer.
// Input channel in_ch carries one transaction per datagram payload byte (mode 0)
// or per opcode table write (mode 1); last_byte marks a datagram's final byte.
// Each byte updates the message parse; results (message complete, datagram done,
// unknown opcode stop, truncated) leave on out_ch, one per transaction, with
// last_in_run set on the final result caused by a byte. A byte causes at most two.
// opcode_count is loaded through cfg_we / cfg_wdata; the user must load it only
// while the block is idle, as the block does not enforce this. Throughput: one
// input transaction per cycle while in_ch.ready is high. A byte is registered at
// its acceptance (table read happens at the same edge), parsed from the input
// register once the queue can take two results, and written to a four-entry
// result queue. in_ch.ready drops only while the queue cannot take two
// results; a receiver stall fills the queue and then holds the input register.
// Reset clears the parse state, the queue and opcode_count; the opcode table is
// not cleared and must be written before the opcodes it serves are used.
module opcode_message_deframer #(
  parameter int NUM_OPCODES        = omd_pkg::NUM_OPCODES_DEF,
  parameter int MAX_DATAGRAM_BYTES = omd_pkg::MAX_DGRAM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [omd_pkg::CFG_W-1:0] cfg_wdata,
  omd_in_if.sink                    in_ch,
  omd_out_if.source                 out_ch
);

  logic            acc;
  logic            busy;
  logic            fire;
  logic            room2;
  logic [1:0]      push_n;
  omd_pkg::entry_t ent;
  omd_pkg::res_t   res0, res1, q;

  assign in_ch.ready = !busy || fire;
  assign acc         = in_ch.valid && in_ch.ready;

  omd_table #(.NUM_OPCODES(NUM_OPCODES)) u_table (
    .clk           (clk),
    .acc           (acc),
    .mode          (in_ch.mode),
    .data_byte     (in_ch.data_byte),
    .entry_index   (in_ch.entry_index),
    .entry_size    (in_ch.entry_size),
    .entry_dynamic (in_ch.entry_dynamic),
    .rd_r          (ent)
  );

  omd_parse #(
    .NUM_OPCODES        (NUM_OPCODES),
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .mode      (in_ch.mode),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .ent       (ent),
    .room2     (room2),
    .busy      (busy),
    .fire      (fire),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1)
  );

  omd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .d0        (res0),
    .d1        (res1),
    .room2     (room2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .q         (q)
  );

  assign out_ch.kind           = q.kind;
  assign out_ch.msg_opcode     = q.msg_opcode;
  assign out_ch.body_offset    = q.body_offset;
  assign out_ch.payload_length = q.payload_length;
  assign out_ch.last_in_run    = q.last_in_run;

endmodule

FILE: hdl/omd_table.sv
// Opcode table memory: written by table transactions, read at each payload byte for use at the opcode high byte.
module omd_table #(
  parameter int NUM_OPCODES = omd_pkg::NUM_OPCODES_DEF
) (
  input  logic             clk,
  input  logic             acc,
  input  logic             mode,
  input  logic [7:0]       data_byte,
  input  logic [5:0]       entry_index,
  input  logic [15:0]      entry_size,
  input  logic             entry_dynamic,
  output omd_pkg::entry_t  rd_r
);

  localparam int IDX_W = (NUM_OPCODES > 1) ? $clog2(NUM_OPCODES) : 1;

  omd_pkg::entry_t mem [NUM_OPCODES];
  logic [7:0]  prev_byte_r;
  logic [15:0] rd_addr16;
  logic [15:0] wr_addr16;
  logic        wr_ok;

  // the byte before an opcode high byte is always its low byte
  assign rd_addr16 = {data_byte, prev_byte_r};
  assign wr_addr16 = {10'd0, entry_index};
  assign wr_ok     = {1'b0, wr_addr16} < 17'(NUM_OPCODES);

  always_ff @(posedge clk) begin
    if (acc) begin
      if (mode) begin
        if (wr_ok) begin
          mem[wr_addr16[IDX_W-1:0]] <= '{dynamic: entry_dynamic, size: entry_size};
        end
      end else begin
        rd_r        <= mem[rd_addr16[IDX_W-1:0]];
        prev_byte_r <= data_byte;
      end
    end
  end

endmodule

FILE: hdl/omd_parse.sv
// Parser: input register, phase state and result formation; one byte per cycle while the queue has room.
module omd_parse #(
  parameter int NUM_OPCODES        = omd_pkg::NUM_OPCODES_DEF,
  parameter int MAX_DATAGRAM_BYTES = omd_pkg::MAX_DGRAM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [omd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      acc,
  input  logic                      mode,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  omd_pkg::entry_t           ent,
  input  logic                      room2,
  output logic                      busy,
  output logic                      fire,
  output logic [1:0]                push_n,
  output omd_pkg::res_t             res0,
  output omd_pkg::res_t             res1
);

  localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES);

  logic [omd_pkg::CFG_W-1:0] count_r;
  logic                      v_r;
  logic                      mode_r;
  logic [7:0]                byte_r;
  logic                      last_r;

  omd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      cur_r, cur_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             stop_r, stop_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [15:0]      total_r, total_nxt;

  logic [16:0]      limit;
  logic [POS_W-1:0] after;
  logic [15:0]      word;
  logic             m_valid;
  omd_pkg::res_t    m_res;
  omd_pkg::res_t    e_res;

  assign busy  = v_r;
  assign fire  = v_r && room2;
  assign limit = ({10'd0, count_r} > 17'(NUM_OPCODES)) ? 17'(NUM_OPCODES)
                                                       : {10'd0, count_r};
  assign after = (pos_r == POS_W'(MAX_DATAGRAM_BYTES - 1)) ? '0 : pos_r + 1'b1;
  assign word  = {byte_r, held_r};

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    held_nxt  = held_r;
    stop_nxt  = stop_r;
    start_nxt = start_r;
    total_nxt = total_r;
    m_valid   = 1'b0;
    m_res     = '0;
    e_res     = '0;
    push_n    = 2'd0;
    res0      = '0;
    res1      = '0;
    if (fire && !mode_r) begin
      if (!stop_r) begin
        case (phase_r)
          omd_pkg::PH_OP_LO: begin
            held_nxt  = byte_r;
            phase_nxt = omd_pkg::PH_OP_HI;
          end
          omd_pkg::PH_OP_HI: begin
            cur_nxt = word;
            if ({1'b0, word} >= limit) begin
              stop_nxt  = 1'b1;
              phase_nxt = omd_pkg::PH_OP_LO;
            end else if (ent.dynamic) begin
              phase_nxt = omd_pkg::PH_LEN_LO;
            end else begin
              total_nxt = ent.size;
              rem_nxt   = ent.size;
              start_nxt = after;
              if (ent.size == 16'd0) begin
                m_valid   = 1'b1;
                m_res     = '{kind: omd_pkg::KIND_MSG, msg_opcode: word,
                              body_offset: 11'(after), payload_length: 16'd0,
                              last_in_run: 1'b0};
                phase_nxt = omd_pkg::PH_OP_LO;
              end else begin
                phase_nxt = omd_pkg::PH_BODY;
              end
            end
          end
          omd_pkg::PH_LEN_LO: begin
            held_nxt  = byte_r;
            phase_nxt = omd_pkg::PH_LEN_HI;
          end
          omd_pkg::PH_LEN_HI: begin
            total_nxt = word;
            rem_nxt   = word;
            start_nxt = after;
            if (word == 16'd0) begin
              m_valid   = 1'b1;
              m_res     = '{kind: omd_pkg::KIND_MSG, msg_opcode: cur_r,
                            body_offset: 11'(after), payload_length: 16'd0,
                            last_in_run: 1'b0};
              phase_nxt = omd_pkg::PH_OP_LO;
            end else begin
              phase_nxt = omd_pkg::PH_BODY;
            end
          end
          omd_pkg::PH_BODY: begin
            rem_nxt = rem_r - 16'd1;
            if (rem_nxt == 16'd0) begin
              m_valid   = 1'b1;
              m_res     = '{kind: omd_pkg::KIND_MSG, msg_opcode: cur_r,
                            body_offset: 11'(start_r), payload_length: total_r,
                            last_in_run: 1'b0};
              phase_nxt = omd_pkg::PH_OP_LO;
            end
          end
          default: phase_nxt = omd_pkg::PH_OP_LO;
        endcase
      end
      pos_nxt = after;

      if (last_r) begin
        e_res.last_in_run = 1'b1;
        if (stop_nxt) begin
          e_res.kind       = omd_pkg::KIND_STOP;
          e_res.msg_opcode = cur_nxt;
        end else if (phase_nxt == omd_pkg::PH_OP_LO) begin
          e_res.kind = omd_pkg::KIND_DONE;
        end else if (phase_nxt == omd_pkg::PH_OP_HI) begin
          e_res.kind = omd_pkg::KIND_TRUNC;
        end else begin
          e_res.kind       = omd_pkg::KIND_TRUNC;
          e_res.msg_opcode = cur_nxt;
        end
        phase_nxt = omd_pkg::PH_OP_LO;
        cur_nxt   = '0;
        rem_nxt   = '0;
        pos_nxt   = '0;
        held_nxt  = '0;
        stop_nxt  = 1'b0;
        start_nxt = '0;
        total_nxt = '0;
      end

      if (m_valid && last_r) begin
        push_n = 2'd2;
        res0   = m_res;
        res1   = e_res;
      end else if (m_valid) begin
        push_n            = 2'd1;
        res0              = m_res;
        res0.last_in_run  = 1'b1;
      end else if (last_r) begin
        push_n = 2'd1;
        res0   = e_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      v_r     <= 1'b0;
      phase_r <= omd_pkg::PH_OP_LO;
      cur_r   <= '0;
      rem_r   <= '0;
      pos_r   <= '0;
      held_r  <= '0;
      stop_r  <= 1'b0;
      start_r <= '0;
      total_r <= '0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (acc) begin
        v_r <= 1'b1;
      end else if (fire) begin
        v_r <= 1'b0;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        cur_r   <= cur_nxt;
        rem_r   <= rem_nxt;
        pos_r   <= pos_nxt;
        held_r  <= held_nxt;
        stop_r  <= stop_nxt;
        start_r <= start_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mode_r <= mode;
      byte_r <= data_byte;
      last_r <= last_byte;
    end
  end

`ifndef SYNTHESIS
  a_stop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> phase_r == omd_pkg::PH_OP_LO)
    else $error("stopped datagram left in a mid-message phase");

  a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == omd_pkg::PH_BODY |-> rem_r != 16'd0)
    else $error("payload phase with nothing remaining");

  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !mode_r && last_r |=> pos_r == '0 && !stop_r)
    else $error("parse state not cleared after the last byte");
`endif

endmodule

FILE: hdl/omd_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per transaction.
module omd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  omd_pkg::res_t d0,
  input  omd_pkg::res_t d1,
  output logic          room2,
  output logic          out_valid,
  input  logic          out_ready,
  output omd_pkg::res_t q
);

  localparam int PTR_W = $clog2(omd_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(omd_pkg::FIFO_DEPTH + 1);

  omd_pkg::res_t   mem [omd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;
  logic [PTR_W-1:0] wptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = count_r != '0;
  assign room2     = count_r <= CNT_W'(omd_pkg::FIFO_DEPTH - 2);
  assign q         = mem[rptr_r];
  assign wptr1     = wptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr_r] <= d0;
    end
    if (push_n == 2'd2) begin
      mem[wptr1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + PTR_W'(push_n);
      rptr_r  <= rptr_r + PTR_W'(pop);
      count_r <= count_r + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> count_r <= CNT_W'(omd_pkg::FIFO_DEPTH - 2))
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(omd_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != CNT_W'(omd_pkg::FIFO_DEPTH) |-> PTR_W'(wptr_r - rptr_r) == PTR_W'(count_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: tb/tb_opcode_message_deframer.sv
// Testbench for opcode_message_deframer: random datagrams checked against a predictor.
`timescale 1ns / 100ps

module tb_opcode_message_deframer;

  localparam int CLK_PERIOD  = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_SLACK = 6;

  typedef struct packed {
    bit        mode;
    bit [7:0]  data_byte;
    bit        last_byte;
    bit [5:0]  entry_index;
    bit [15:0] entry_size;
    bit        entry_dynamic;
  } in_item_t;

  typedef bit [7:0] byte_q_t[$];

  // Predicts the message and end records of the deframer and checks them in order.
  class deframe_scoreboard;
    bit [16:0]       op_table [64];
    bit [6:0]        op_count;
    omd_pkg::phase_t phase;
    bit [15:0]       cur_op;
    bit [15:0]       remaining;
    bit [15:0]       msg_len;
    bit [10:0]       pos;
    bit [10:0]       msg_off;
    bit [7:0]        low_hold;
    bit              stopped;
    omd_pkg::res_t   pending [$];
    int              errors;

    function new();
      op_count = '0;
      errors   = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase     = omd_pkg::PH_OP_LO;
      cur_op    = '0;
      remaining = '0;
      msg_len   = '0;
      pos       = '0;
      msg_off   = '0;
      low_hold  = '0;
      stopped   = 1'b0;
    endfunction

    function void set_count(bit [6:0] v);
      op_count = v;
    endfunction

    function omd_pkg::res_t rec(logic [1:0] kind, bit [15:0] op, bit [10:0] off,
                                bit [15:0] len);
      omd_pkg::res_t r;
      r.kind           = kind;
      r.msg_opcode     = op;
      r.body_offset    = off;
      r.payload_length = len;
      r.last_in_run    = 1'b0;
      return r;
    endfunction

    // header complete: either an empty message right away or a body to count down
    function void open_body(bit [15:0] len, bit [10:0] nxt, ref omd_pkg::res_t runs[$]);
      msg_len   = len;
      remaining = len;
      msg_off   = nxt;
      if (len == 16'd0) begin
        runs.push_back(rec(omd_pkg::KIND_MSG, cur_op, nxt, 16'd0));
        phase = omd_pkg::PH_OP_LO;
      end else begin
        phase = omd_pkg::PH_BODY;
      end
    endfunction

    function void note_input(in_item_t it);
      omd_pkg::res_t runs [$];
      bit [10:0]     nxt;
      bit [6:0]      lim;
      if (it.mode) begin
        op_table[it.entry_index] = {it.entry_dynamic, it.entry_size};
        return;
      end
      lim = (op_count > 7'd64) ? 7'd64 : op_count;
      nxt = pos + 11'd1;
      if (!stopped) begin
        case (phase)
          omd_pkg::PH_OP_LO: begin
            low_hold = it.data_byte;
            phase    = omd_pkg::PH_OP_HI;
          end
          omd_pkg::PH_OP_HI: begin
            cur_op = {it.data_byte, low_hold};
            if (cur_op >= {9'd0, lim}) begin
              stopped = 1'b1;
              phase   = omd_pkg::PH_OP_LO;
            end else if (op_table[cur_op[5:0]][16]) begin
              phase = omd_pkg::PH_LEN_LO;
            end else begin
              open_body(op_table[cur_op[5:0]][15:0], nxt, runs);
            end
          end
          omd_pkg::PH_LEN_LO: begin
            low_hold = it.data_byte;
            phase    = omd_pkg::PH_LEN_HI;
          end
          omd_pkg::PH_LEN_HI: begin
            open_body({it.data_byte, low_hold}, nxt, runs);
          end
          default: begin
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) begin
              runs.push_back(rec(omd_pkg::KIND_MSG, cur_op, msg_off, msg_len));
              phase = omd_pkg::PH_OP_LO;
            end
          end
        endcase
      end
      pos = nxt;
      if (it.last_byte) begin
        if (stopped)
          runs.push_back(rec(omd_pkg::KIND_STOP, cur_op, 11'd0, 16'd0));
        else if (phase == omd_pkg::PH_OP_LO)
          runs.push_back(rec(omd_pkg::KIND_DONE, 16'd0, 11'd0, 16'd0));
        else if (phase == omd_pkg::PH_OP_HI)
          runs.push_back(rec(omd_pkg::KIND_TRUNC, 16'd0, 11'd0, 16'd0));
        else
          runs.push_back(rec(omd_pkg::KIND_TRUNC, cur_op, 11'd0, 16'd0));
        clear_parse();
      end
      if (runs.size() != 0) runs[runs.size()-1].last_in_run = 1'b1;
      foreach (runs[i]) pending.push_back(runs[i]);
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(omd_pkg::res_t got);
      omd_pkg::res_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d, msg_opcode 0x%0h", got.kind, got.msg_opcode);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp("kind", {14'd0, want.kind}, {14'd0, got.kind});
      cmp("msg_opcode", want.msg_opcode, got.msg_opcode);
      cmp("body_offset", {5'd0, want.body_offset}, {5'd0, got.body_offset});
      cmp("payload_length", want.payload_length, got.payload_length);
      cmp("last_in_run", {15'd0, want.last_in_run}, {15'd0, got.last_in_run});
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [omd_pkg::CFG_W-1:0] cfg_wdata;
  bit                        idle_on = 1'b1;
  bit                        hold_req = 1'b0;
  int                        quiet_cycles = 0;
  int                        sent_items = 0;
  deframe_scoreboard         sb = new();

  omd_in_if  in_ch ();
  omd_out_if out_ch ();

  opcode_message_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // result and input monitor; results are checked before the new input is noted
  always @(posedge clk) begin
    omd_pkg::res_t got;
    in_item_t      seen;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind           = out_ch.kind;
        got.msg_opcode     = out_ch.msg_opcode;
        got.body_offset    = out_ch.body_offset;
        got.payload_length = out_ch.payload_length;
        got.last_in_run    = out_ch.last_in_run;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.mode          = in_ch.mode;
        seen.data_byte     = in_ch.data_byte;
        seen.last_byte     = in_ch.last_byte;
        seen.entry_index   = in_ch.entry_index;
        seen.entry_size    = in_ch.entry_size;
        seen.entry_dynamic = in_ch.entry_dynamic;
        sb.note_input(seen);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // result receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 24) : 1'b1;
    end
  end

  function automatic bit [16:0] rand_entry();
    bit [15:0] sz;
    case ($urandom_range(0, 9))
      0: sz = 16'd0;
      1: sz = 16'hFFFF;
      2: sz = 16'($urandom);
      default: sz = 16'($urandom_range(1, 8));
    endcase
    return {($urandom_range(0, 3) == 0), sz};
  endfunction

  // table write; data_byte and last_byte carry noise the block must ignore
  function automatic in_item_t write_item(bit [5:0] idx, bit [16:0] ent);
    in_item_t it;
    it.mode          = 1'b1;
    it.data_byte     = 8'($urandom);
    it.last_byte     = 1'($urandom);
    it.entry_index   = idx;
    it.entry_size    = ent[15:0];
    it.entry_dynamic = ent[16];
    return it;
  endfunction

  function automatic in_item_t byte_item(bit [7:0] b, bit last);
    in_item_t it;
    it.mode          = 1'b0;
    it.data_byte     = b;
    it.last_byte     = last;
    it.entry_index   = 6'($urandom);
    it.entry_size    = 16'($urandom);
    it.entry_dynamic = 1'($urandom);
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while (idle_on && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= it.mode;
    in_ch.data_byte     <= it.data_byte;
    in_ch.last_byte     <= it.last_byte;
    in_ch.entry_index   <= it.entry_index;
    in_ch.entry_size    <= it.entry_size;
    in_ch.entry_dynamic <= it.entry_dynamic;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_bytes(byte_q_t q, int write_pct);
    foreach (q[i]) begin
      if ($urandom_range(0, 99) < write_pct)
        send_item(write_item(6'($urandom), rand_entry()));
      send_item(byte_item(q[i], i == q.size() - 1));
    end
  endtask

  // mostly well-formed messages, some unknown opcodes and cut-off tails
  task automatic random_datagram(int trunc_pct);
    byte_q_t   q;
    int        nmsg;
    int        lim;
    int        cut;
    bit [15:0] op;
    bit [15:0] len;
    bit [16:0] ent;
    lim  = (sb.op_count > 7'd64) ? 64 : int'(sb.op_count);
    nmsg = $urandom_range(0, 4);
    for (int m = 0; m < nmsg; m++) begin
      if (lim == 0 || $urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 2))
          0: op = 16'(lim);
          1: op = 16'hFFFF;
          default: op = 16'($urandom_range(lim, 65535));
        endcase
        q.push_back(op[7:0]);
        q.push_back(op[15:8]);
        repeat ($urandom_range(0, 4)) q.push_back(8'($urandom));
        break;
      end
      op  = 16'($urandom_range(0, lim - 1));
      ent = sb.op_table[op[5:0]];
      q.push_back(op[7:0]);
      q.push_back(op[15:8]);
      if (ent[16]) begin
        len = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
        q.push_back(len[7:0]);
        q.push_back(len[15:8]);
      end else begin
        len = ent[15:0];
      end
      // too long to finish: the datagram ends inside the body
      if (len > 16'd40) begin
        repeat ($urandom_range(0, 5)) q.push_back(8'($urandom));
        break;
      end
      repeat (len) q.push_back(8'($urandom));
    end
    if (q.size() > 1 && $urandom_range(0, 99) < trunc_pct) begin
      cut = $urandom_range(1, q.size() - 1);
      while (q.size() > cut) void'(q.pop_back());
    end
    if (q.size() == 0) q.push_back(8'($urandom));
    send_bytes(q, 3);
  endtask

  task automatic random_items(int n, int trunc_pct);
    int start;
    start = sent_items;
    while (sent_items - start < n) begin
      if ($urandom_range(0, 9) == 0)
        send_item(write_item(6'($urandom), rand_entry()));
      else
        random_datagram(trunc_pct);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
    // trailing table writes produce nothing but may still be in flight
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_count(bit [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_count(v);
  endtask

  initial begin
    bit [16:0] ent;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.last_byte     = 1'b0;
    in_ch.entry_index   = '0;
    in_ch.entry_size    = '0;
    in_ch.entry_dynamic = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_count(7'd64);
    // the table is undefined after reset: load every entry first
    for (int i = 0; i < 64; i++) begin
      case (i)
        0:  ent = {1'b0, 16'd0};
        1:  ent = {1'b1, 16'd0};
        2:  ent = {1'b0, 16'd3};
        3:  ent = {1'b1, 16'hFFFF};
        62: ent = {1'b0, 16'h8000};
        63: ent = {1'b0, 16'hFFFF};
        default: ent = rand_entry();
      endcase
      send_item(write_item(6'(i), ent));
    end

    send_bytes('{8'h00, 8'h00}, 0);                 // empty message, then done
    send_bytes('{8'h02, 8'h00, 8'hAA, 8'hBB, 8'hCC}, 0);
    send_bytes('{8'h01, 8'h00, 8'h00, 8'h00}, 0);   // dynamic length of zero
    send_bytes('{8'h3F, 8'h00, 8'h11}, 0);          // cut off in a huge body
    send_bytes('{8'h05}, 0);                        // cut off inside the opcode
    send_bytes('{8'h40, 8'h00, 8'hDE, 8'hAD}, 0);   // opcode at the limit stops
    send_bytes('{8'hFF, 8'hFF}, 0);
    send_bytes('{8'h01, 8'h00, 8'h05}, 0);          // cut off inside the length

    hold_req = 1'b1;
    random_items(130, 15);
    wait_drained();

    write_count(7'd0);
    random_items(30, 10);
    wait_drained();

    write_count(7'd127);
    idle_on = 1'b0;
    random_items(80, 15);
    idle_on = 1'b1;
    random_items(70, 15);
    wait_drained();

    write_count(7'd1);
    send_item(write_item(6'd0, {1'b0, 16'd2}));
    random_items(50, 15);
    wait_drained();

    write_count(7'($urandom_range(2, 63)));
    random_items(80, 15);

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: opcode_message_deframer.f
hdl/omd_pkg.sv
hdl/omd_if.sv
hdl/omd_table.sv
hdl/omd_parse.sv
hdl/omd_fifo.sv
hdl/opcode_message_deframer.sv
tb/tb_opcode_message_deframer.sv
